### rtl/core/piru_pkg.sv
package piru_pkg;

  localparam int WORD_W        = 32;
  localparam int PIX_W         = 8;
  localparam int COL_W         = 12;
  localparam int CODE_W        = 2;
  localparam int RW_W          = 13;
  localparam int POS_W         = 5;
  localparam int CFG_IDX_W     = 1;
  localparam int DEF_MAX_WIDTH = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 1'd1;

  localparam logic [CODE_W-1:0] RST_PIXEL_SIZE = 2'd3;
  localparam logic [RW_W-1:0]   RST_ROW_WIDTH  = 13'd1;

  // last pixel slot in a word is (32 >> code) - 1
  localparam logic [POS_W-1:0] LAST_SLOT_BASE = 5'd31;

  typedef struct packed {
    logic              load;
    logic [POS_W-1:0]  bit_pos;
    logic              row_end;
    logic              word_end;
  } piru_step_t;

endpackage

### rtl/core/piru_extract.sv
module piru_extract
  import piru_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [POS_W-1:0]  bit_pos,
  input  logic [CODE_W-1:0] size_code,
  output logic [PIX_W-1:0]  pixel
);

  logic [7:0] byte_sel;
  logic [3:0] bits;
  logic [3:0] shamt;
  logic [7:0] mask;
  logic [7:0] shifted;

  always_comb begin
    byte_sel = 8'(word >> {bit_pos[4:3], 3'b000});
    bits     = 4'(4'd1 << size_code);
    shamt    = 4'd8 - {1'b0, bit_pos[2:0]} - bits;
    mask     = 8'((9'd1 << bits) - 9'd1);
    shifted  = byte_sel >> shamt;
    pixel    = shifted & mask;
  end

endmodule

### rtl/core/piru_ctrl.sv
module piru_ctrl
  import piru_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              advance,
  input  logic [CODE_W-1:0] size_code,
  input  logic [RW_W-1:0]   row_width,
  output logic              busy,
  output piru_step_t        step,
  output logic [COL_W-1:0]  column
);

  localparam int CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (CNT_W + 1 > RW_W + 1) ? CNT_W + 1 : RW_W + 1;

  logic              busy_r, busy_nxt;
  logic [POS_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CMP_W-1:0]  eff_w;
  logic [CMP_W-1:0]  cnt_plus;
  logic              last_row;
  logic              last_word;

  always_comb begin
    priority if (row_width == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(row_width) > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = CMP_W'(row_width);
    end
    cnt_plus  = CMP_W'(count_r) + CMP_W'(1);
    last_row  = (cnt_plus >= eff_w);
    last_word = last_row || (slot_r == (LAST_SLOT_BASE >> size_code));
  end

  always_comb begin
    busy_nxt  = busy_r;
    slot_nxt  = slot_r;
    count_nxt = count_r;
    if (start) begin
      busy_nxt = 1'b1;
      slot_nxt = '0;
    end else if (advance) begin
      slot_nxt = slot_r + POS_W'(1);
      if (last_word) begin
        busy_nxt = 1'b0;
      end
      if (last_row) begin
        count_nxt = '0;
      end else begin
        count_nxt = CNT_W'(cnt_plus);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      slot_r  <= '0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      slot_r  <= slot_nxt;
      count_r <= count_nxt;
    end
  end

  assign busy          = busy_r;
  assign step.load     = advance;
  assign step.bit_pos  = POS_W'(slot_r << size_code);
  assign step.row_end  = last_row;
  assign step.word_end = last_word;
  assign column        = COL_W'(count_r);

endmodule

### rtl/core/packed_index_row_unpacker.sv
// Channel  Ports                          Moves
// in       in_valid/in_ready              one 32-bit word of packed indices
// out      out_valid/out_ready            one pixel index with column and marks
// cfg      cfg_valid/cfg_ready            register index and write data
//
// Each accepted word yields 32/bits results, fewer when a row ends inside the word, at one
// result per cycle unless out_ready stalls, from the single pixel shifter and slot counter.
// in_ready is low while a word is being unpacked; a stalled out_ready holds the sequencer.
// Reset is synchronous: column count 0, 8 bits per pixel, row width 1.
module packed_index_row_unpacker
  import piru_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_W-1:0]    in_data_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_pixel_index,
  output logic [COL_W-1:0]     out_column,
  output logic                 out_row_end,
  output logic                 out_word_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RW_W-1:0]      cfg_data
);

  logic [CODE_W-1:0] size_code_r;
  logic [RW_W-1:0]   row_width_r;
  logic [WORD_W-1:0] word_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  pixel_r;
  logic [COL_W-1:0]  column_r;
  logic              row_end_r;
  logic              word_end_r;

  logic              busy;
  logic              start;
  logic              advance;
  piru_step_t        step;
  logic [COL_W-1:0]  column;
  logic [PIX_W-1:0]  pixel;

  assign in_ready  = !busy;
  assign cfg_ready = 1'b1;
  assign start     = in_valid && in_ready;
  assign advance   = busy && (!out_valid_r || out_ready);

  piru_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .advance   (advance),
    .size_code (size_code_r),
    .row_width (row_width_r),
    .busy      (busy),
    .step      (step),
    .column    (column)
  );

  piru_extract u_extract (
    .word      (word_r),
    .bit_pos   (step.bit_pos),
    .size_code (size_code_r),
    .pixel     (pixel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_code_r <= RST_PIXEL_SIZE;
      row_width_r <= RST_ROW_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PIXEL_SIZE: size_code_r <= CODE_W'(cfg_data);
        REG_ROW_WIDTH:  row_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word_r <= in_data_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.load) begin
      pixel_r    <= pixel;
      column_r   <= column;
      row_end_r  <= step.row_end;
      word_end_r <= step.word_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = pixel_r;
  assign out_column      = column_r;
  assign out_row_end     = row_end_r;
  assign out_word_end    = word_end_r;

endmodule

### rtl/core/piru_checker.sv
module piru_checker
  import piru_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIX_W-1:0]     out_pixel_index,
  input logic [COL_W-1:0]     out_column,
  input logic                 out_row_end,
  input logic                 out_word_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_index)
      && $stable(out_column) && $stable(out_row_end) && $stable(out_word_end))
    else $error("result changed while stalled");

  a_row_ends_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_end |-> out_word_end)
    else $error("row end without word end");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a word");

  a_word_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_word_end |=> out_valid)
    else $error("word results interrupted");

  a_new_row_col0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_row_end |=> !out_valid || out_column == '0)
    else $error("new row does not start at column zero");

endmodule

bind packed_index_row_unpacker piru_checker u_piru_checker (.*);
